### rtl/bis_pkg.sv
// Shared types and constants of the bicubic image scaler.
package bis_pkg;

    // Request opcodes
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_SRC_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_SRC_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_SCALE_X    = 2'd2;
    localparam logic [1:0] CFG_SCALE_Y    = 2'd3;

    localparam int SIZE_W  = 10;
    localparam int SCALE_W = 24;
    localparam int DST_W   = 12;
    localparam int POS_W   = DST_W + SCALE_W;   // Q20.16 source position
    localparam int FRAC_W  = 16;
    localparam int INT_W   = POS_W - FRAC_W;
    localparam int TAP_W   = 18;                // kernel distance, Q2.16
    localparam int WGT_W   = 16;                // 1-D weight, signed Q2.14
    localparam int WT_W    = 32;                // tap weight, Q28
    localparam int SUM_W   = 40;

    localparam logic signed [WT_W-1:0] MIN_WSUM = 32'sd268435;

    typedef struct packed {
        logic        opcode;
        logic [8:0]  src_row;
        logic [8:0]  src_col;
        logic [7:0]  pixel_in;
        logic [11:0] dst_row;
        logic [11:0] dst_col;
    } t_in_req;

    typedef struct packed {
        logic [7:0]  pixel_out;
        logic [11:0] out_row;
        logic [11:0] out_col;
        logic        used_fallback;
    } t_out_req;

    // Classified request held in the queue between front and back
    typedef struct packed {
        logic             is_load;
        logic [8:0]       src_row;
        logic [8:0]       src_col;
        logic [7:0]       pixel_in;
        logic [11:0]      dst_row;
        logic [11:0]      dst_col;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
    } t_job;

    // Tag that travels alongside the kernel pipeline
    typedef struct packed {
        logic       vld;
        logic [2:0] idx;
    } t_ktag;

endpackage

### rtl/bis_kernel.sv
// Three-stage pipeline that evaluates the cubic kernel weight of one distance.
module bis_kernel (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  bis_pkg::t_ktag           i_tag,
    input  logic [bis_pkg::TAP_W-1:0] i_t,
    output bis_pkg::t_ktag           o_tag,
    output logic signed [bis_pkg::WGT_W-1:0] o_wgt
);
    import bis_pkg::*;

    localparam logic [TAP_W-1:0] T_ONE = 18'd65536;
    localparam logic [TAP_W-1:0] T_TWO = 18'd131072;
    localparam logic signed [63:0] K_LO  = 64'sd1 <<< 49;
    localparam logic signed [63:0] K_HI  = 64'sd1 <<< 50;
    localparam logic signed [63:0] K_RND = (64'sd1 <<< 34) + (64'sd1 <<< 49);

    t_ktag                   r_tag0, r_tag1, r_tag2;
    logic [35:0]             r_t2;
    logic signed [20:0]      r_lin;
    logic [TAP_W-1:0]        r_t0, r_t1;
    logic                    r_ge0, r_ge1;
    logic                    r_zero0, r_zero1;
    logic signed [57:0]      r_prod;
    logic signed [WGT_W-1:0] r_wgt;

    logic signed [20:0] lin;
    logic signed [63:0] nsum;
    logic signed [63:0] bsum;
    logic [16:0]        wv;

    // Linear factor of the active kernel segment
    always_comb begin
        if (i_t >= T_ONE) begin
            lin = 21'sd327680 - $signed({3'b000, i_t});
        end else begin
            lin = $signed({3'b000, i_t}) * 21'sd3 - 21'sd327680;
        end
    end

    // Add the segment constant, round to Q2.14
    always_comb begin
        if (r_ge1) begin
            nsum = 64'(r_prod) + K_HI - ($signed({46'b0, r_t1}) <<< 35);
        end else begin
            nsum = 64'(r_prod) + K_LO;
        end
        bsum = nsum + K_RND;
        wv   = bsum[51:35] - 17'd16384;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag0 <= '0;
            r_tag1 <= '0;
            r_tag2 <= '0;
        end else begin
            r_tag0 <= i_tag;
            r_tag1 <= r_tag0;
            r_tag2 <= r_tag1;
        end
        // stage 0: square the distance
        r_t2    <= 36'(i_t) * 36'(i_t);
        r_lin   <= lin;
        r_t0    <= i_t;
        r_ge0   <= (i_t >= T_ONE);
        r_zero0 <= (i_t >= T_TWO);
        // stage 1: cubic term
        r_prod  <= $signed({1'b0, r_t2}) * r_lin;
        r_t1    <= r_t0;
        r_ge1   <= r_ge0;
        r_zero1 <= r_zero0;
        // stage 2: weight
        r_wgt   <= r_zero1 ? '0 : $signed(wv[WGT_W-1:0]);
    end

    assign o_tag = r_tag2;
    assign o_wgt = r_wgt;

endmodule

### rtl/bis_front.sv
// Front end: accepts requests, drops out-of-range ones, maps position, queues.
module bis_front #(
    parameter int MAX_WIDTH   = 512,
    parameter int MAX_HEIGHT  = 512,
    parameter int MAX_DST_DIM = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  bis_pkg::t_in_req            i_in_data,
    input  logic [bis_pkg::SCALE_W-1:0] i_scale_x,
    input  logic [bis_pkg::SCALE_W-1:0] i_scale_y,
    input  logic                        i_pop,
    output logic                        o_job_vld,
    output bis_pkg::t_job               o_job
);
    import bis_pkg::*;

    t_job       r_q [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_cnt;

    logic accept, keep, push, pop;
    t_job job;

    // Classify: keep in-storage loads and in-range computes
    always_comb begin
        if (i_in_data.opcode == OP_LOAD) begin
            keep = (32'(i_in_data.src_row) < MAX_HEIGHT) && (32'(i_in_data.src_col) < MAX_WIDTH);
        end else begin
            keep = (32'(i_in_data.dst_row) < MAX_DST_DIM) && (32'(i_in_data.dst_col) < MAX_DST_DIM);
        end
        job.is_load  = (i_in_data.opcode == OP_LOAD);
        job.src_row  = i_in_data.src_row;
        job.src_col  = i_in_data.src_col;
        job.pixel_in = i_in_data.pixel_in;
        job.dst_row  = i_in_data.dst_row;
        job.dst_col  = i_in_data.dst_col;
        job.pos_x    = POS_W'(i_in_data.dst_col) * POS_W'(i_scale_x);
        job.pos_y    = POS_W'(i_in_data.dst_row) * POS_W'(i_scale_y);
    end

    assign o_in_stall = (r_cnt == 2'd2);
    assign accept     = i_in_valid && !o_in_stall;
    assign push       = accept && keep;
    assign pop        = i_pop && (r_cnt != 2'd0);

    // Two-entry queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (push) r_wptr <= !r_wptr;
            if (pop)  r_rptr <= !r_rptr;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
        if (push) r_q[r_wptr] <= job;
    end

    assign o_job_vld = (r_cnt != 2'd0);
    assign o_job     = r_q[r_rptr];

endmodule

### rtl/bis_back.sv
// Back end: source image store, weight and tap sequencer, divider, result register.
module bis_back #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int WW = $clog2(MAX_WIDTH + 1),
    parameter int HW = $clog2(MAX_HEIGHT + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_vld,
    input  bis_pkg::t_job      i_job,
    output logic               o_pop,
    input  logic [WW-1:0]      i_width,
    input  logic [HW-1:0]      i_height,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output bis_pkg::t_out_req  o_out_data
);
    import bis_pkg::*;

    localparam int CW        = $clog2(MAX_WIDTH);
    localparam int RW        = $clog2(MAX_HEIGHT);
    localparam int MEM_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW        = $clog2(MEM_DEPTH);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_WGT  = 7'b0000010,
        S_TAP  = 7'b0000100,
        S_DIV  = 7'b0001000,
        S_QUO  = 7'b0010000,
        S_NEAR = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [4:0] r_cnt, n_cnt;

    logic [7:0]              r_mem [MEM_DEPTH];
    logic [7:0]              r_rd;
    logic [POS_W-1:0]        r_px, r_py;
    logic [11:0]             r_dr, r_dc;
    logic signed [WGT_W-1:0] r_wx [4];
    logic signed [WGT_W-1:0] r_wy [4];
    logic signed [SUM_W-1:0] r_sum;
    logic signed [WT_W-1:0]  r_wsum;
    logic [SUM_W-1:0]        r_rem, r_dsh;
    logic [7:0]              r_quo;
    logic                    r_fb;
    logic                    r_t1_vld, r_t2_vld;
    logic signed [WT_W-1:0]  r_t1_wt, r_t2_wt;
    logic signed [SUM_W-1:0] r_t2_prod;
    logic                    r_ovld;
    t_out_req                r_out;

    logic                    take, out_free;
    logic                    tap_issue, inb;
    logic [1:0]              ix, iy;
    logic [21:0]             tx, ty;
    logic [20:0]             nx, ny, nxc, nyc;
    logic [AW-1:0]           rd_addr, wr_addr;
    logic                    rd_en;
    logic [FRAC_W-1:0]       frac;
    logic [TAP_W-1:0]        kt;
    t_ktag                   ktag_i, ktag_o;
    logic signed [WGT_W-1:0] kw;
    logic signed [SUM_W-1:0] wsh8;

    assign take     = (r_state == S_IDLE) && i_job_vld;
    assign o_pop    = take;
    assign out_free = !r_ovld || !i_out_stall;

    // Kernel distances: four x taps, then four y taps
    always_comb begin
        frac = r_cnt[2] ? r_py[FRAC_W-1:0] : r_px[FRAC_W-1:0];
        case (r_cnt[1:0])
            2'd0:    kt = 18'd65536 + TAP_W'(frac);
            2'd1:    kt = TAP_W'(frac);
            2'd2:    kt = 18'd65536 - TAP_W'(frac);
            default: kt = 18'd131072 - TAP_W'(frac);
        endcase
        ktag_i.vld = (r_state == S_WGT) && (r_cnt < 5'd8);
        ktag_i.idx = r_cnt[2:0];
    end

    bis_kernel u_kernel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (ktag_i),
        .i_t     (kt),
        .o_tag   (ktag_o),
        .o_wgt   (kw)
    );

    // Tap position and bounds
    always_comb begin
        ix        = r_cnt[1:0];
        iy        = r_cnt[3:2];
        tx        = 22'(r_px[POS_W-1:FRAC_W]) + 22'(ix) - 22'd1;
        ty        = 22'(r_py[POS_W-1:FRAC_W]) + 22'(iy) - 22'd1;
        inb       = (tx < 22'(i_width)) && (ty < 22'(i_height));
        tap_issue = (r_state == S_TAP) && (r_cnt < 5'd16);
        nx        = 21'(r_px[POS_W-1:FRAC_W]) + 21'(r_px[FRAC_W-1]);
        ny        = 21'(r_py[POS_W-1:FRAC_W]) + 21'(r_py[FRAC_W-1]);
        nxc       = (nx >= 21'(i_width))  ? 21'(i_width - 1'b1)  : nx;
        nyc       = (ny >= 21'(i_height)) ? 21'(i_height - 1'b1) : ny;
        if (r_state == S_NEAR) begin
            rd_addr = AW'(nyc[RW-1:0]) * AW'(MAX_WIDTH) + AW'(nxc[CW-1:0]);
        end else begin
            rd_addr = AW'(ty[RW-1:0]) * AW'(MAX_WIDTH) + AW'(tx[CW-1:0]);
        end
        rd_en   = tap_issue || (r_state == S_NEAR);
        wr_addr = AW'(i_job.src_row) * AW'(MAX_WIDTH) + AW'(i_job.src_col);
        wsh8    = SUM_W'(r_wsum) <<< 8;
    end

    // Source image store
    always_ff @(posedge i_clk) begin
        if (take && i_job.is_load) r_mem[wr_addr] <= i_job.pixel_in;
        if (rd_en) r_rd <= r_mem[rd_addr];
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt + 5'd1;
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (take && !i_job.is_load) n_state = S_WGT;
            end
            S_WGT: begin
                if (r_cnt == 5'd9) begin
                    n_state = S_TAP;
                    n_cnt   = '0;
                end
            end
            S_TAP: begin
                if (r_cnt == 5'd17) n_state = S_DIV;
            end
            S_DIV: begin
                n_cnt = '0;
                if (r_wsum <= MIN_WSUM)           n_state = S_NEAR;
                else if (r_sum <= 0 || r_sum >= wsh8) n_state = S_DONE;
                else                              n_state = S_QUO;
            end
            S_QUO: begin
                if (r_cnt == 5'd7) n_state = S_DONE;
            end
            S_NEAR: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_t1_vld <= 1'b0;
            r_t2_vld <= 1'b0;
            r_ovld   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_t1_vld <= tap_issue && inb;
            r_t2_vld <= r_t1_vld;
            if (r_ovld && !i_out_stall) r_ovld <= 1'b0;
            if (r_state == S_DONE && out_free) r_ovld <= 1'b1;
        end

        // latch an accepted request
        if (take) begin
            r_px   <= i_job.pos_x;
            r_py   <= i_job.pos_y;
            r_dr   <= i_job.dst_row;
            r_dc   <= i_job.dst_col;
            r_sum  <= '0;
            r_wsum <= '0;
        end

        // collect kernel weights
        if (ktag_o.vld) begin
            if (ktag_o.idx[2]) r_wy[ktag_o.idx[1:0]] <= kw;
            else               r_wx[ktag_o.idx[1:0]] <= kw;
        end

        // tap multiply-accumulate
        r_t1_wt   <= r_wx[ix] * r_wy[iy];
        r_t2_prod <= $signed({1'b0, r_rd}) * r_t1_wt;
        r_t2_wt   <= r_t1_wt;
        if (r_t2_vld) begin
            r_sum  <= r_sum + r_t2_prod;
            r_wsum <= r_wsum + r_t2_wt;
        end

        // normalize
        if (r_state == S_DIV) begin
            r_fb  <= (r_wsum <= MIN_WSUM);
            r_rem <= r_sum;
            r_dsh <= SUM_W'(r_wsum) << 7;
            if (r_sum <= 0)        r_quo <= 8'd0;
            else if (r_sum >= wsh8) r_quo <= 8'd255;
        end
        if (r_state == S_QUO) begin
            if (r_rem >= r_dsh) begin
                r_rem <= r_rem - r_dsh;
                r_quo <= {r_quo[6:0], 1'b1};
            end else begin
                r_quo <= {r_quo[6:0], 1'b0};
            end
            r_dsh <= r_dsh >> 1;
        end

        // result register
        if (r_state == S_DONE && out_free) begin
            r_out.pixel_out     <= r_fb ? r_rd : r_quo;
            r_out.out_row       <= r_dr;
            r_out.out_col       <= r_dc;
            r_out.used_fallback <= r_fb;
        end
    end

    assign o_out_valid = r_ovld;
    assign o_out_data  = r_out;

endmodule

### rtl/bicubic_image_scaler_unit.sv
// Top level of the bicubic image scaler: configuration registers, front and back.
//
//   channel  | direction | handshake                 | payload
//   request  | in        | i_in_valid / o_in_stall   | i_in_data  (t_in_req)
//   result   | out       | o_out_valid / i_out_stall | o_out_data (t_out_req)
//   config   | in        | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// A load writes the image store when the back end takes it; a compute runs the
// eight kernel weights through the shared kernel pipeline, then the sixteen taps
// through the single image read port and multiply-accumulate, then the
// bit-serial divide, or reads the nearest pixel instead of dividing.
// Synchronous active-low reset clears control state and loads register defaults.
// The two-entry queue keeps taking requests, until it is full, while the back end
// works or its result waits under stall.
module bicubic_image_scaler_unit #(
    parameter int MAX_WIDTH   = 512,
    parameter int MAX_HEIGHT  = 512,
    parameter int MAX_DST_DIM = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  bis_pkg::t_in_req            i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output bis_pkg::t_out_req           o_out_data,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [bis_pkg::SCALE_W-1:0] i_cfg_data
);
    import bis_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic [SIZE_W-1:0]  r_cfg_w, r_cfg_h;
    logic [SCALE_W-1:0] r_scale_x, r_scale_y;
    logic [31:0]        ew, eh;
    logic [WW-1:0]      eff_w;
    logic [HW-1:0]      eff_h;
    logic               job_vld, pop;
    t_job               job;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w   <= 10'd512;
            r_cfg_h   <= 10'd512;
            r_scale_x <= 24'd65536;
            r_scale_y <= 24'd65536;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SRC_WIDTH:  r_cfg_w   <= i_cfg_data[SIZE_W-1:0];
                CFG_SRC_HEIGHT: r_cfg_h   <= i_cfg_data[SIZE_W-1:0];
                CFG_SCALE_X:    r_scale_x <= i_cfg_data;
                default:        r_scale_y <= i_cfg_data;
            endcase
        end
    end

    // Effective size: zero acts as one, saturate at storage size
    always_comb begin
        ew = 32'(r_cfg_w);
        eh = 32'(r_cfg_h);
        if (ew == 32'd0) ew = 32'd1;
        if (ew > 32'(MAX_WIDTH)) ew = 32'(MAX_WIDTH);
        if (eh == 32'd0) eh = 32'd1;
        if (eh > 32'(MAX_HEIGHT)) eh = 32'(MAX_HEIGHT);
        eff_w = ew[WW-1:0];
        eff_h = eh[HW-1:0];
    end

    bis_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .MAX_DST_DIM (MAX_DST_DIM)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_scale_x  (r_scale_x),
        .i_scale_y  (r_scale_y),
        .i_pop      (pop),
        .o_job_vld  (job_vld),
        .o_job      (job)
    );

    bis_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .WW         (WW),
        .HW         (HW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_vld   (job_vld),
        .i_job       (job),
        .o_pop       (pop),
        .i_width     (eff_w),
        .i_height    (eff_h),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

### rtl/bis_checker.sv
// Port-level checks of the bicubic image scaler, bound to the top level.
module bis_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input bis_pkg::t_out_req o_out_data
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped or changed under stall");

    // Come out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("not empty after reset");

    // Keep both handshake outputs known once out of reset
    a_hs_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown({o_out_valid, o_in_stall}))
        else $error("handshake output unknown");

    // Queue never reports full unless requests arrived
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(i_in_valid))
        else $error("stall without incoming request");

endmodule

bind bicubic_image_scaler_unit bis_checker u_bis_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
